// File: rtl/core/ryc_pkg.sv
// ryc_pkg: shared constants and types for the rgb to Yxy converter
// depends on nothing; used by ryc_matrix, ryc_cell and rgb_to_yxy_convert

package ryc_pkg;

    localparam int PIX_W  = 16;
    localparam int COEF_W = 16;
    localparam int PROD_W = 32;
    localparam int SUM_W  = 34;
    localparam int REM_W  = SUM_W + 1;
    localparam int FRAC_W = 16;
    // one divider cell per quotient bit
    localparam int DIV_CELLS = FRAC_W;

    localparam logic [COEF_W-1:0] COEF_XR = 16'd27031;
    localparam logic [COEF_W-1:0] COEF_XG = 16'd23434;
    localparam logic [COEF_W-1:0] COEF_XB = 16'd11824;
    localparam logic [COEF_W-1:0] COEF_YR = 16'd13938;
    localparam logic [COEF_W-1:0] COEF_YG = 16'd46869;
    localparam logic [COEF_W-1:0] COEF_YB = 16'd4730;
    localparam logic [COEF_W-1:0] COEF_ZR = 16'd1267;
    localparam logic [COEF_W-1:0] COEF_ZG = 16'd7811;
    localparam logic [COEF_W-1:0] COEF_ZB = 16'd62274;

    typedef struct packed {
        logic [REM_W-1:0]  rem_x;
        logic [REM_W-1:0]  rem_y;
        logic [SUM_W-1:0]  den;
        logic [FRAC_W-1:0] quo_x;
        logic [FRAC_W-1:0] quo_y;
        logic [PIX_W-1:0]  luma;
        logic              zero;
        logic              last;
    } cell_data_t;

endpackage

// File: rtl/core/ryc_matrix.sv
// ryc_matrix: three-stage 3x3 matrix multiply, luma rounding and divider setup
// depends on ryc_pkg

module ryc_matrix
    import ryc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [PIX_W-1:0] red,
    input  logic [PIX_W-1:0] green,
    input  logic [PIX_W-1:0] blue,
    input  logic             last_in,
    output logic             out_valid,
    output cell_data_t       out_data
);

    logic [PROD_W-1:0] prod_reg [9];
    logic              last1_reg, last2_reg;
    logic              v1_reg, v2_reg, v3_reg;
    logic [PROD_W-1:0] cx_reg, cy_reg;
    logic [PROD_W:0]   cz_reg;
    cell_data_t        data_reg;

    logic [SUM_W-1:0]  sum;
    logic [PROD_W:0]   luma_round;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg[0] <= COEF_XR * red;
            prod_reg[1] <= COEF_XG * green;
            prod_reg[2] <= COEF_XB * blue;
            prod_reg[3] <= COEF_YR * red;
            prod_reg[4] <= COEF_YG * green;
            prod_reg[5] <= COEF_YB * blue;
            prod_reg[6] <= COEF_ZR * red;
            prod_reg[7] <= COEF_ZG * green;
            prod_reg[8] <= COEF_ZB * blue;
            last1_reg   <= last_in;
        end
    end

    // row sums; X and Y rows never pass 32 bits, Z needs 33
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg    <= prod_reg[0] + prod_reg[1] + prod_reg[2];
            cy_reg    <= prod_reg[3] + prod_reg[4] + prod_reg[5];
            cz_reg    <= {1'b0, prod_reg[6]} + {1'b0, prod_reg[7]} + {1'b0, prod_reg[8]};
            last2_reg <= last1_reg;
        end
    end

    assign sum = {2'b00, cx_reg} + {2'b00, cy_reg} + {1'b0, cz_reg};
    assign luma_round = {1'b0, cy_reg} + (PROD_W+1)'(32'h8000);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg.rem_x <= {{(REM_W-PROD_W){1'b0}}, cx_reg};
            data_reg.rem_y <= {{(REM_W-PROD_W){1'b0}}, cy_reg};
            data_reg.den   <= sum;
            data_reg.quo_x <= '0;
            data_reg.quo_y <= '0;
            data_reg.luma  <= luma_round[PROD_W] ? {PIX_W{1'b1}}
                                                 : luma_round[PROD_W-1 -: PIX_W];
            data_reg.zero  <= (sum == '0);
            data_reg.last  <= last2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/core/ryc_cell.sv
// ryc_cell: one restoring-division cell, one quotient bit of x and y per cell
// depends on ryc_pkg

module ryc_cell
    import ryc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  cell_data_t in_data,
    output logic       out_valid,
    output cell_data_t out_data
);

    logic       valid_reg;
    cell_data_t data_reg;
    cell_data_t data_next;

    logic [REM_W-1:0] shift_x, shift_y, den_ext;
    logic             ge_x, ge_y;

    always_comb
    begin
        den_ext = {1'b0, in_data.den};
        shift_x = {in_data.rem_x[REM_W-2:0], 1'b0};
        shift_y = {in_data.rem_y[REM_W-2:0], 1'b0};
        ge_x    = shift_x >= den_ext;
        ge_y    = shift_y >= den_ext;
        data_next       = in_data;
        data_next.rem_x = ge_x ? shift_x - den_ext : shift_x;
        data_next.rem_y = ge_y ? shift_y - den_ext : shift_y;
        data_next.quo_x = {in_data.quo_x[FRAC_W-2:0], ge_x};
        data_next.quo_y = {in_data.quo_y[FRAC_W-2:0], ge_y};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/core/rgb_to_yxy_convert.sv
// rgb_to_yxy_convert: linear rgb pixel stream to CIE Yxy, top level
// depends on ryc_pkg, ryc_matrix and ryc_cell
//
// usage
//   pixel channel: red, green, blue (unsigned Q8.8) and last_in, qualified by
//   pix_valid; a transfer happens on a rising edge with pix_valid high and
//   pix_stall low
//   result channel: luma_y (Q8.8), chroma_x, chroma_y (Q0.16), zero_sum and
//   last_out, qualified by res_valid; the receiver holds it with res_stall
//   path: the matrix and setup stages, then one divider cell per quotient
//   bit, 16 cells in all
//   throughput: one pixel per cycle while no result waits under res_stall,
//   set by the divider chain, which retires one quotient bit of x and of y per cell
//   the whole pipeline moves on one enable; when a result waits under
//   res_stall the pipe freezes and pix_stall rises, and payloads hold
//   reset clears the valid bits only; no result is shown until a pixel
//   has flowed through

module rgb_to_yxy_convert
    import ryc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pix_valid,
    output logic              pix_stall,
    input  logic [PIX_W-1:0]  red,
    input  logic [PIX_W-1:0]  green,
    input  logic [PIX_W-1:0]  blue,
    input  logic              last_in,
    output logic              res_valid,
    input  logic              res_stall,
    output logic [PIX_W-1:0]  luma_y,
    output logic [FRAC_W-1:0] chroma_x,
    output logic [FRAC_W-1:0] chroma_y,
    output logic              zero_sum,
    output logic              last_out
);

    // pipeline advance
    logic       en;
    logic       chain_valid [DIV_CELLS+1];
    cell_data_t chain_data  [DIV_CELLS+1];

    assign en        = !(res_valid && res_stall);
    assign pix_stall = !en;

    ryc_matrix u_matrix
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pix_valid),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .last_in   (last_in),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    // divider chain, one quotient bit per cell, msb first
    for (genvar i = 0; i < DIV_CELLS; i++)
    begin : g_cell
        ryc_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // last cell doubles as the output register
    assign res_valid = chain_valid[DIV_CELLS];
    assign luma_y    = chain_data[DIV_CELLS].luma;
    assign zero_sum  = chain_data[DIV_CELLS].zero;
    assign last_out  = chain_data[DIV_CELLS].last;
    // an all-zero pixel drives the divider with a zero divisor; mask it
    assign chroma_x  = chain_data[DIV_CELLS].zero ? '0 : chain_data[DIV_CELLS].quo_x;
    assign chroma_y  = chain_data[DIV_CELLS].zero ? '0 : chain_data[DIV_CELLS].quo_y;

    a_zero_chroma: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && zero_sum |-> chroma_x == '0 && chroma_y == '0)
        else $error("zero sum with nonzero chroma");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(luma_y) && $stable(chroma_x))
        else $error("stalled result changed");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> res_valid)
        else $error("input stalled with no waiting result");

endmodule
